// ----- hdl/int128_alu_booth_restoring_core_macros.svh -----
`ifndef INT128_ALU_BOOTH_RESTORING_CORE_MACROS_SVH
`define INT128_ALU_BOOTH_RESTORING_CORE_MACROS_SVH
// implication check, clocked, reset gated
`define ALU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication check
`define ALU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/i128alu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package i128alu_pkg;
  localparam int W = 128;
  localparam int CW = 8;
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_AND = 4'd4;
  localparam logic [3:0] OP_OR  = 4'd5;
  localparam logic [3:0] OP_XOR = 4'd6;
  localparam logic [3:0] OP_NOT = 4'd7;
  localparam logic [3:0] OP_SHL = 4'd8;
  localparam logic [3:0] OP_SHR = 4'd9;
  localparam logic [3:0] OP_ROL = 4'd10;
  localparam logic [3:0] OP_ROR = 4'd11;
  localparam logic [3:0] OP_CMP = 4'd12;

  typedef struct packed {
    logic         iter;
    logic         is_mul;
    logic         negate;
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic         dz;
    logic         lt;
    logic         eq;
    logic         gt;
  } job_t;

  typedef struct packed {
    logic [W-1:0] res;
    logic         dz;
    logic         lt;
    logic         eq;
    logic         gt;
  } res_t;
endpackage
`default_nettype wire

// ----- hdl/i128alu_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module i128alu_front import i128alu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_req_type,
  input  wire logic [63:0] in_a_low,
  input  wire logic [63:0] in_a_high,
  input  wire logic [63:0] in_b_low,
  input  wire logic [63:0] in_b_high,
  input  wire logic [7:0]  in_shift_amount,
  output logic             q_valid,
  input  wire logic        q_ready,
  output job_t             q_job
);
  logic [1:0] cnt_r, cnt_nxt;
  job_t       buf_r [2];
  logic       wp_r, rp_r;
  job_t       j;
  logic [W-1:0] a, b, an, bn, sum, dif;
  logic [6:0] rl;

  assign a = {in_a_high, in_a_low};
  assign b = {in_b_high, in_b_low};
  assign sum = a + b;
  assign dif = a - b;
  assign an = a[W-1] ? (~a + 1'b1) : a;
  assign bn = b[W-1] ? (~b + 1'b1) : b;

  always_comb begin
    j = '0;
    rl = in_shift_amount[6:0];
    if (in_req_type == OP_ROR) rl = 7'(~in_shift_amount[6:0] + 7'd1);
    unique case (in_req_type) inside
      OP_ADD: j.x = sum;
      OP_SUB: j.x = dif;
      OP_MUL: begin
        j.iter = 1'b1; j.is_mul = 1'b1; j.x = a; j.y = b;
      end
      OP_DIV: begin
        if (b == '0) j.dz = 1'b1;
        else begin
          j.iter = 1'b1; j.x = an; j.y = bn; j.negate = a[W-1] ^ b[W-1];
        end
      end
      OP_AND: j.x = a & b;
      OP_OR:  j.x = a | b;
      OP_XOR: j.x = a ^ b;
      OP_NOT: j.x = ~a;
      OP_SHL: j.x = in_shift_amount[7] ? '0 : a << in_shift_amount[6:0];
      OP_SHR: j.x = in_shift_amount[7] ? '0 : a >> in_shift_amount[6:0];
      OP_ROL, OP_ROR: j.x = (a << rl) | (a >> (7'(W - 1) - rl) >> 1);
      OP_CMP: begin
        j.eq = (a == b);
        j.lt = $signed(a) < $signed(b);
        j.gt = $signed(a) > $signed(b);
      end
      default: j = '0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_job    = buf_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
    end
    if (in_valid && in_ready) buf_r[wp_r] <= j;
  end
endmodule
`default_nettype wire

// ----- hdl/i128alu_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "int128_alu_booth_restoring_core_macros.svh"
module i128alu_back import i128alu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire job_t q_job,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]   st_r;
  logic [CW-1:0] k_r;
  logic         mul_r, neg_r, q1_r, ov_r;
  logic [W-1:0] acc_r, q_r, m_r;
  res_t         res_r;
  logic [W-1:0] addv, shr_acc, rem_sh;
  logic [W:0]   trial;
  logic         take;

  assign q_ready = (st_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_res = res_r;

  always_comb begin
    addv = acc_r;
    if (q_r[0] && !q1_r) addv = acc_r - m_r;
    else if (!q_r[0] && q1_r) addv = acc_r + m_r;
    shr_acc = {addv[W-1], addv[W-1:1]};
    rem_sh = {acc_r[W-2:0], q_r[W-1]};
    trial = {acc_r[W-1], rem_sh} - {1'b0, m_r};
    take = !trial[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid && q_ready) begin
          if (q_job.iter) st_r <= S_RUN;
          else begin
            ov_r <= 1'b1;
            res_r <= '{res: q_job.x, dz: q_job.dz, lt: q_job.lt, eq: q_job.eq,
                       gt: q_job.gt};
          end
        end
        S_RUN: if (k_r == CW'(W - 1)) st_r <= S_FIN;
        S_FIN: if (!ov_r || out_ready) begin
          st_r <= S_IDLE; ov_r <= 1'b1;
          res_r <= '{res: neg_r ? (~q_r + 1'b1) : q_r, dz: 1'b0, lt: 1'b0,
                     eq: 1'b0, gt: 1'b0};
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid && q_ready) begin
      k_r <= '0; mul_r <= q_job.is_mul; neg_r <= q_job.negate && !q_job.is_mul;
      q1_r <= 1'b0; acc_r <= '0; m_r <= q_job.y; q_r <= q_job.x;
      if (q_job.is_mul) begin m_r <= q_job.x; q_r <= q_job.y; end
    end else if (st_r == S_RUN) begin
      k_r <= k_r + 1'b1;
      if (mul_r) begin
        q1_r <= q_r[0];
        q_r <= {addv[0], q_r[W-1:1]};
        acc_r <= shr_acc;
      end else begin
        acc_r <= take ? trial[W-1:0] : rem_sh;
        q_r <= {q_r[W-2:0], take};
      end
    end
  end

  `ALU_ASSERT_IMP(a_busy_no_take, clk, rst_n, st_r != S_IDLE, !q_ready, "took while busy")
  `ALU_ASSERT_NXT(a_fin_out, clk, rst_n, st_r == S_FIN && !ov_r, ov_r, "finish lost")
  `ALU_ASSERT_IMP(a_flags_excl, clk, rst_n, ov_r, !(res_r.lt && res_r.gt), "lt and gt")
  `ALU_ASSERT_NXT(a_run_count, clk, rst_n, st_r == S_RUN && k_r != CW'(W - 1),
                  st_r == S_RUN, "early end")
endmodule
`default_nettype wire

// ----- hdl/int128_alu_booth_restoring_core.sv -----
// single-step ops: one per cycle while the iterative unit is idle and the output is not stalled;
//   multiply/divide hold the iterative unit, which takes no new job until it has registered its
//   result, over the 128-step Booth (multiply) or restoring (divide) shift/add loop
// a two-entry queue separates decode from the iterative unit
// reset: synchronous active-low rst_n clears queue, sequencer and output valid
`timescale 1ns / 1ps
`default_nettype none
module int128_alu_booth_restoring_core import i128alu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_req_type,
  input  wire logic [63:0] in_a_low,
  input  wire logic [63:0] in_a_high,
  input  wire logic [63:0] in_b_low,
  input  wire logic [63:0] in_b_high,
  input  wire logic [7:0]  in_shift_amount,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_result_low,
  output logic [63:0]      out_result_high,
  output logic             out_divide_by_zero,
  output logic             out_less_than,
  output logic             out_equal_to,
  output logic             out_greater_than
);
  logic q_valid, q_ready;
  job_t q_job;
  res_t r;

  i128alu_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_a_low, .in_a_high,
    .in_b_low, .in_b_high, .in_shift_amount, .q_valid, .q_ready, .q_job
  );

  i128alu_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_job, .out_valid, .out_ready, .out_res(r)
  );

  assign out_result_low     = r.res[63:0];
  assign out_result_high    = r.res[127:64];
  assign out_divide_by_zero = r.dz;
  assign out_less_than      = r.lt;
  assign out_equal_to       = r.eq;
  assign out_greater_than   = r.gt;
endmodule
`default_nettype wire

// ----- tb/int128_alu_booth_restoring_core_checker.sv -----
`timescale 1ns / 1ps
module int128_alu_booth_restoring_core_checker import i128alu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_req_type,
  input  logic [63:0] in_a_low,
  input  logic [63:0] in_a_high,
  input  logic [63:0] in_b_low,
  input  logic [63:0] in_b_high,
  input  logic [7:0]  in_shift_amount,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_result_low,
  input  logic [63:0] out_result_high,
  input  logic        out_divide_by_zero,
  input  logic        out_less_than,
  input  logic        out_equal_to,
  input  logic        out_greater_than,
  output int          fail_count,
  output int          pending
);

  res_t alu_results[$];

  function automatic logic [W-1:0] booth_product(logic [W-1:0] m, logic [W-1:0] q);
    logic [W-1:0] acc;
    logic         q1;
    acc = '0;
    q1 = 1'b0;
    for (int k = 0; k < W; k++) begin
      if (q[0] && !q1) acc = acc - m;
      if (!q[0] && q1) acc = acc + m;
      q1 = q[0];
      q = {acc[0], q[W-1:1]};
      acc = {acc[W-1], acc[W-1:1]};
    end
    return q;
  endfunction

  function automatic logic [W-1:0] signed_quotient(logic [W-1:0] a, logic [W-1:0] b);
    logic [W-1:0] q, m, rem;
    logic         ext;
    q = a[W-1] ? -a : a;
    m = b[W-1] ? -b : b;
    rem = '0;
    for (int k = 0; k < W; k++) begin
      ext = rem[W-1];
      rem = {rem[W-2:0], q[W-1]};
      q = q << 1;
      if (ext || rem >= m) begin
        rem = rem - m;
        q[0] = 1'b1;
      end
    end
    return (a[W-1] != b[W-1]) ? -q : q;
  endfunction

  function automatic res_t alu_compute(logic [3:0] op, logic [W-1:0] a, logic [W-1:0] b,
                                       logic [7:0] amt);
    res_t r;
    int   rot;
    r = '0;
    rot = amt % W;
    case (op)
      OP_ADD: r.res = a + b;
      OP_SUB: r.res = a - b;
      OP_MUL: r.res = booth_product(a, b);
      OP_DIV: begin
        if (b == '0) r.dz = 1'b1;
        else r.res = signed_quotient(a, b);
      end
      OP_AND: r.res = a & b;
      OP_OR:  r.res = a | b;
      OP_XOR: r.res = a ^ b;
      OP_NOT: r.res = ~a;
      OP_SHL: r.res = (amt >= W) ? '0 : a << amt;
      OP_SHR: r.res = (amt >= W) ? '0 : a >> amt;
      OP_ROL: r.res = (a << rot) | ((rot == 0) ? '0 : a >> (W - rot));
      OP_ROR: r.res = (a >> rot) | ((rot == 0) ? '0 : a << (W - rot));
      OP_CMP: begin
        r.lt = $signed(a) < $signed(b);
        r.gt = $signed(a) > $signed(b);
        r.eq = a == b;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = alu_results.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n) begin
      if (in_valid && in_ready)
        alu_results.push_back(alu_compute(in_req_type, {in_a_high, in_a_low},
                                          {in_b_high, in_b_low}, in_shift_amount));
      if (out_valid && out_ready) begin
        got = {out_result_high, out_result_low, out_divide_by_zero, out_less_than,
               out_equal_to, out_greater_than};
        if (alu_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count = fail_count + 1;
        end else begin
          want = alu_results.pop_front();
          if (got.res !== want.res) begin
            $display("%0t: result expected %h actual %h", $time, want.res, got.res);
            fail_count = fail_count + 1;
          end
          if (got.dz !== want.dz || got.lt !== want.lt || got.eq !== want.eq ||
              got.gt !== want.gt) begin
            $display("%0t: flags dz/lt/eq/gt expected %b%b%b%b actual %b%b%b%b", $time,
                     want.dz, want.lt, want.eq, want.gt, got.dz, got.lt, got.eq, got.gt);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/int128_alu_booth_restoring_core_tb.sv -----
`timescale 1ns / 1ps
module int128_alu_booth_restoring_core_tb import i128alu_pkg::*;;
  localparam int NUM_RANDOM = 2000;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_req_type = OP_ADD;
  logic [63:0] in_a_low = '0;
  logic [63:0] in_a_high = '0;
  logic [63:0] in_b_low = '0;
  logic [63:0] in_b_high = '0;
  logic [7:0]  in_shift_amount = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result_low;
  logic [63:0] out_result_high;
  logic        out_divide_by_zero;
  logic        out_less_than;
  logic        out_equal_to;
  logic        out_greater_than;
  int          fail_count;
  int          pending;
  logic        stall_enable = 1'b1;
  logic        hold_off = 1'b0;
  int          idle_cycles = 0;

  always #6 clk = ~clk;

  int128_alu_booth_restoring_core uut (.*);

  int128_alu_booth_restoring_core_checker checker_i (.*);

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return 64'(($urandom_range(0, 40)));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_request(logic [3:0] op, logic [127:0] a, logic [127:0] b,
                              logic [7:0] amt);
    in_valid <= 1'b1;
    in_req_type <= op;
    {in_a_high, in_a_low} <= a;
    {in_b_high, in_b_low} <= b;
    in_shift_amount <= amt;
    do @(posedge clk); while (!in_ready);
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (in_valid && in_ready || out_valid && out_ready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (stall_enable && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        k = $urandom_range(1, 15);
        repeat (k - 1) @(posedge clk);
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    logic [127:0] max_neg;
    logic [127:0] a;
    logic [127:0] b;
    logic [3:0]   op;
    max_neg = {1'b1, 127'b0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_ADD, '1, 128'd1, 8'd0);
    send_request(OP_SUB, '0, 128'd1, 8'd0);
    send_request(OP_MUL, '1, '1, 8'd0);
    send_request(OP_MUL, max_neg, 128'd3, 8'd0);
    send_request(OP_DIV, 128'd100, '0, 8'd0);
    send_request(OP_DIV, max_neg, '1, 8'd0);
    send_request(OP_DIV, -128'sd7, 128'd2, 8'd0);
    send_request(OP_DIV, 128'd7, -128'sd2, 8'd0);
    send_request(OP_AND, '1, 128'h5a5a, 8'd0);
    send_request(OP_OR, max_neg, 128'd1, 8'd0);
    send_request(OP_XOR, '1, max_neg, 8'd0);
    send_request(OP_NOT, '0, '0, 8'd0);
    send_request(OP_SHL, '1, '0, 8'd127);
    send_request(OP_SHL, '1, '0, 8'd128);
    send_request(OP_SHR, '1, '0, 8'd255);
    send_request(OP_ROL, 128'h1234_5678, '0, 8'd200);
    send_request(OP_ROR, 128'h1234_5678, '0, 8'd128);
    send_request(OP_CMP, max_neg, 128'd1, 8'd0);
    send_request(OP_CMP, 128'd5, 128'd5, 8'd0);
    send_request(OP_CMP, '0, '1, 8'd0);
    send_request(4'd13, '1, '1, 8'd255);
    send_request(4'd15, '1, '1, 8'd255);
    drain();

    // receiver holds off while requests keep coming
    hold_off <= 1'b1;
    fork
      repeat (300) @(posedge clk);
      for (int i = 0; i < 8; i++)
        send_request(4'($urandom_range(0, 12)), {rand_word(), rand_word()},
                     {rand_word(), rand_word()}, 8'($urandom));
    join_any
    hold_off <= 1'b0;
    wait fork;
    drain();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - 200) stall_enable <= 1'b0;
      if (i % 500 == 250) drain();
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15)) :
           (($urandom_range(0, 3) == 0) ? 4'($urandom_range(2, 3)) :
            4'($urandom_range(0, 12)));
      a = {rand_word(), rand_word()};
      b = {rand_word(), rand_word()};
      if ($urandom_range(0, 9) == 0) b = a;
      send_request(op, a, b, 8'($urandom));
    end
    drain();
    repeat (140) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
